// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sequence store RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sss_pkg.sv =====
// Shared types and codes for the sequence store.
// No dependencies; used by sss_cell and the top level.
package sss_pkg;

  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_APPEND     = 2'd1;
  localparam logic [1:0] CMD_DELETE     = 2'd2;

  localparam logic [1:0] ST_DONE        = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NO_POS      = 2'd2;

  localparam int POS_WIDTH   = 6;
  localparam int FIELD_WIDTH = 32;

  // Per-cell source select; at most one bit is set, none means hold.
  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
    logic from_head;
  } cell_ctrl_t;

endpackage

// ===== rtl/sequence_store_insert_delete_top.sv =====
// Sequence store: a chain of cells holding an ordered list of signed values.
// A command is applied in its accept cycle and the first result is valid on the
// next cycle. Each command then emits max(count,1) results, one per
// cycle while out_ready is high, by rotating the chain one cell per result;
// no new command is taken until the last result has been accepted.
// Reset clears the count and the control state; cell contents are left as is.
`include "assert_macros.svh"

module sequence_store_insert_delete_top #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] value,
  input  logic [5:0]  position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] element,
  output logic        is_last,
  output logic        list_empty,
  output logic [1:0]  status
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > sss_pkg::POS_WIDTH) ? CW : sss_pkg::POS_WIDTH;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic                   state;
  logic                   state_next;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [CW-1:0]          remaining;
  logic [CW-1:0]          remaining_next;
  logic [1:0]             status_next;

  logic                   in_acc;
  logic                   out_acc;
  logic                   full;
  logic                   do_push;
  logic                   do_append;
  logic                   do_delete;
  logic                   do_rotate;
  logic [CMPW-1:0]        pos_ext;
  logic [CMPW-1:0]        count_ext;
  logic [CW-1:0]          tail_idx;
  logic [VALUE_WIDTH-1:0] fit;

  logic [VALUE_WIDTH-1:0] cells [DEPTH];

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_LIST);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign full      = (count == CW'(DEPTH));
  assign pos_ext   = CMPW'(position);
  assign count_ext = CMPW'(count);
  assign tail_idx  = count - CW'(1);

  assign do_push   = in_acc && (command == sss_pkg::CMD_PUSH_FRONT) && !full;
  assign do_append = in_acc && (command == sss_pkg::CMD_APPEND) && !full;
  assign do_delete = in_acc && (command == sss_pkg::CMD_DELETE) && (pos_ext < count_ext);
  assign do_rotate = out_acc && (count != '0);

  // Fit the input to the stored width, sign-extending where it is wider.
  // Present the stored value sign-extended or trimmed to the field width.
  if (VALUE_WIDTH <= sss_pkg::FIELD_WIDTH) begin : g_narrow
    assign fit = value[VALUE_WIDTH-1:0];
    if (VALUE_WIDTH < sss_pkg::FIELD_WIDTH) begin : g_ext
      assign element = list_empty ? '0 :
        {{(sss_pkg::FIELD_WIDTH - VALUE_WIDTH){cells[0][VALUE_WIDTH-1]}}, cells[0]};
    end else begin : g_same
      assign element = list_empty ? '0 : cells[0];
    end
  end else begin : g_wide
    assign fit = {{(VALUE_WIDTH - sss_pkg::FIELD_WIDTH){value[31]}}, value};
    assign element = list_empty ? '0 : cells[0][sss_pkg::FIELD_WIDTH-1:0];
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    sss_pkg::cell_ctrl_t    ctrl;
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = fit;
    end else begin : g_mid_l
      assign left = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_mid_r
      assign right = cells[i+1];
    end

    always_comb begin
      ctrl.load       = (do_push && (i == 0)) || (do_append && (count == CW'(i)));
      ctrl.from_left  = do_push && (i != 0);
      ctrl.from_right = (do_delete && (CMPW'(i) >= pos_ext)) ||
                        (do_rotate && (tail_idx != CW'(i)));
      ctrl.from_head  = do_rotate && (tail_idx == CW'(i));
    end

    sss_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_value(fit),
      .left     (left),
      .right    (right),
      .head     (cells[0]),
      .entry    (cells[i])
    );
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    status_next    = status;
    if (in_acc) begin
      status_next = sss_pkg::ST_DONE;
      if (command == sss_pkg::CMD_PUSH_FRONT || command == sss_pkg::CMD_APPEND) begin
        if (full) begin
          status_next = sss_pkg::ST_FULL;
        end
      end else if (command == sss_pkg::CMD_DELETE) begin
        if (!do_delete) begin
          status_next = sss_pkg::ST_NO_POS;
        end
      end
      if (do_push || do_append) begin
        count_next = count + CW'(1);
      end else if (do_delete) begin
        count_next = count - CW'(1);
      end
      // An empty listing still gives one item.
      remaining_next = (count_next == '0) ? CW'(1) : count_next;
      state_next     = S_LIST;
    end else if (out_acc) begin
      remaining_next = remaining - CW'(1);
      if (is_last) begin
        state_next = S_IDLE;
      end
    end
  end

  assign is_last    = (remaining == CW'(1));
  assign list_empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      status    <= sss_pkg::ST_DONE;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      status    <= status_next;
    end
  end

  `CHK_SAME(a_one_side, in_ready, !out_valid, "input taken while a listing is pending")
  `CHK_NEXT(a_list_starts, in_valid && in_ready, out_valid && (remaining != '0), "no listing after an item")
  `CHK_SAME(a_empty_form, out_valid && list_empty, is_last && (element == 32'd0), "bad empty listing")
  `CHK_NEXT(a_last_frees, out_valid && out_ready && is_last, in_ready, "block stuck after last item")

endmodule

// ===== rtl/sss_cell.sv =====
// One storage cell of the sequence chain: holds a single entry.
// Depends on sss_pkg for the cell control struct.
module sss_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  sss_pkg::cell_ctrl_t    ctrl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [VALUE_WIDTH-1:0] left,
  input  logic [VALUE_WIDTH-1:0] right,
  input  logic [VALUE_WIDTH-1:0] head,
  output logic [VALUE_WIDTH-1:0] entry
);

  logic [VALUE_WIDTH-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    if (ctrl.load) begin
      entry_next = new_value;
    end else if (ctrl.from_left) begin
      entry_next = left;
    end else if (ctrl.from_right) begin
      entry_next = right;
    end else if (ctrl.from_head) begin
      entry_next = head;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== sim/tb_sequence_store_insert_delete_top.sv =====
// Testbench for sequence_store_insert_delete_top: drives front inserts, appends and
// positional deletes and checks every listing entry against a mirror of the store.
// Depends on sss_pkg and the top-level RTL only.
module tb_sequence_store_insert_delete_top;

  localparam int          DEPTH       = 64;
  localparam int          TOTAL_ITEMS = 470;
  localparam int          CALM_ITEMS  = 50;
  localparam logic [1:0]  CMD_SPARE   = 2'd3;

  typedef struct {
    logic [31:0] element;
    logic        is_last;
    logic        list_empty;
    logic [1:0]  status;
  } listing_entry_t;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX, MODE_NOISE} stim_mode_t;

  // Mirror of the stored sequence plus the listing entries still owed by the block.
  class store_mirror;
    logic [31:0]    cells [DEPTH];
    int             fill;
    listing_entry_t due [$];
    int             errors, entries_checked, full_drops, missed_deletes, deepest;

    function new();
      fill = 0;
      errors = 0;
      entries_checked = 0;
      full_drops = 0;
      missed_deletes = 0;
      deepest = 0;
    endfunction

    function void apply_command(logic [1:0] cmd, logic [31:0] val, logic [5:0] pos);
      logic [1:0]     st;
      listing_entry_t e;
      int             i;
      st = sss_pkg::ST_DONE;
      if (cmd == sss_pkg::CMD_PUSH_FRONT || cmd == sss_pkg::CMD_APPEND) begin
        if (fill >= DEPTH) begin
          st = sss_pkg::ST_FULL;
          full_drops++;
        end else if (cmd == sss_pkg::CMD_PUSH_FRONT) begin
          for (i = fill; i > 0; i--) cells[i] = cells[i-1];
          cells[0] = val;
          fill++;
        end else begin
          cells[fill] = val;
          fill++;
        end
      end else if (cmd == sss_pkg::CMD_DELETE) begin
        if (pos >= fill) begin
          st = sss_pkg::ST_NO_POS;
          missed_deletes++;
        end else begin
          for (i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
          fill--;
        end
      end
      if (fill > deepest) deepest = fill;
      if (fill == 0) begin
        e.element = '0;
        e.is_last = 1'b1;
        e.list_empty = 1'b1;
        e.status = st;
        due.push_back(e);
      end else begin
        for (i = 0; i < fill; i++) begin
          e.element = cells[i];
          e.is_last = (i + 1 == fill);
          e.list_empty = 1'b0;
          e.status = st;
          due.push_back(e);
        end
      end
    endfunction

    function void compare_entry(logic [31:0] el, logic last, logic empty, logic [1:0] st);
      listing_entry_t e;
      entries_checked++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: listing entry with nothing outstanding, element %h", $time, el);
        return;
      end
      e = due.pop_front();
      if (el !== e.element) begin
        errors++;
        $display("%0t: element expected %h actual %h", $time, e.element, el);
      end
      if (last !== e.is_last) begin
        errors++;
        $display("%0t: is_last expected %b actual %b", $time, e.is_last, last);
      end
      if (empty !== e.list_empty) begin
        errors++;
        $display("%0t: list_empty expected %b actual %b", $time, e.list_empty, empty);
      end
      if (st !== e.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_SPARE;
  logic [31:0] value = '0;
  logic [5:0]  position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] element;
  logic        is_last;
  logic        list_empty;
  logic [1:0]  status;

  store_mirror mirror = new();
  int          items_taken = 0;
  bit          calm = 1'b0;

  sequence_store_insert_delete_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .value      (value),
    .position   (position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .element    (element),
    .is_last    (is_last),
    .list_empty (list_empty),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("sequence_store_insert_delete_top verification failed");
    $finish;
  end

  // Offer one item, with an occasional idle burst first; valid stays high after acceptance.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] val, input logic [5:0] pos);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    position <= pos;
    do @(posedge clk); while (!in_ready);
    mirror.apply_command(cmd, val, pos);
    items_taken++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_live_position();
    if (mirror.fill == 0) return 6'($urandom_range(0, 63));
    case ($urandom_range(0, 3))
      0:       return 6'(0);
      1:       return 6'(mirror.fill - 1);
      default: return 6'($urandom_range(0, mirror.fill - 1));
    endcase
  endfunction

  task automatic send_insert();
    send_item($urandom_range(0, 1) ? sss_pkg::CMD_APPEND : sss_pkg::CMD_PUSH_FRONT,
              pick_value(), 6'($urandom_range(0, 63)));
  endtask

  task automatic random_item(input stim_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   if (r < 80) send_insert();
                   else send_item(sss_pkg::CMD_DELETE, $urandom, pick_live_position());
      MODE_SHRINK: if (r < 25) send_insert();
                   else send_item(sss_pkg::CMD_DELETE, $urandom, pick_live_position());
      MODE_MIX:    if (r < 45) send_insert();
                   else if (r < 90)
                     send_item(sss_pkg::CMD_DELETE, $urandom, pick_live_position());
                   else send_item(CMD_SPARE, $urandom, 6'($urandom_range(0, 63)));
      default:     if (r < 30) send_item(CMD_SPARE, $urandom, 6'($urandom_range(0, 63)));
                   else if (r < 65)
                     send_item(sss_pkg::CMD_DELETE, $urandom, 6'($urandom_range(0, 63)));
                   else send_insert();
    endcase
  endtask

  // Fill the store, knock on it while full, then free a place, refill it and delete once more.
  task automatic fill_store();
    while (mirror.fill < DEPTH) send_insert();
    repeat (3) send_insert();
    send_item(CMD_SPARE, $urandom, 6'($urandom_range(0, 63)));
    send_item(sss_pkg::CMD_DELETE, $urandom, 6'(DEPTH - 1));
    send_insert();
    send_item(sss_pkg::CMD_DELETE, $urandom, 6'($urandom_range(0, DEPTH - 1)));
  endtask

  task automatic run_directed();
    send_item(sss_pkg::CMD_DELETE, 32'h0, 6'd0);
    send_item(CMD_SPARE, 32'h1234_5678, 6'd17);
    send_item(sss_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF, 6'd63);
    send_item(sss_pkg::CMD_APPEND, 32'h8000_0000, 6'd0);
    send_item(sss_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF, 6'd42);
    send_item(sss_pkg::CMD_APPEND, 32'h0000_0000, 6'd21);
    send_item(sss_pkg::CMD_PUSH_FRONT, 32'h0000_0001, 6'd0);
    send_item(CMD_SPARE, 32'hFFFF_FFFF, 6'd63);
    send_item(sss_pkg::CMD_DELETE, 32'hFFFF_FFFF, 6'd63);
    send_item(sss_pkg::CMD_DELETE, 32'h0, 6'd5);
    send_item(sss_pkg::CMD_DELETE, 32'h0, 6'd4);
    send_item(sss_pkg::CMD_DELETE, 32'h0, 6'd0);
    send_item(sss_pkg::CMD_DELETE, 32'h0, 6'd1);
    send_item(sss_pkg::CMD_APPEND, 32'hAAAA_AAAA, 6'd0);
    send_item(sss_pkg::CMD_PUSH_FRONT, 32'h5555_5555, 6'd0);
    // drain to empty through the front
    while (mirror.fill > 0) send_item(sss_pkg::CMD_DELETE, $urandom, 6'd0);
    send_item(sss_pkg::CMD_DELETE, 32'hFFFF_FFFF, 6'd0);
  endtask

  // Receiver: check each accepted entry, stall in bursts, and hold off once for a long stretch.
  initial begin
    int  stall_left;
    bit  held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) mirror.compare_entry(element, is_last, list_empty, status);
      if (!held && items_taken >= 120) begin
        held = 1'b1;
        stall_left = 300;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !rst;
      end
    end
  end

  initial begin
    stim_mode_t mode;
    int         mode_left;
    bit         first_fill, second_fill, paused;
    int         wait_cycles;
    mode = MODE_GROW;
    mode_left = 0;
    first_fill = 1'b0;
    second_fill = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    while (items_taken < TOTAL_ITEMS) begin
      calm = (items_taken >= TOTAL_ITEMS - CALM_ITEMS);
      if (!first_fill && items_taken >= 40) begin
        first_fill = 1'b1;
        fill_store();
      end else if (!second_fill && items_taken >= 320) begin
        second_fill = 1'b1;
        fill_store();
      end else if (!paused && items_taken >= 230) begin
        // hold the input until every owed entry has come out
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (mirror.due.size() != 0);
      end else begin
        if (mode_left == 0) begin
          mode = stim_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 30);
        end
        random_item(mode);
        mode_left--;
      end
    end
    in_valid <= 1'b0;
    calm = 1'b1;
    wait_cycles = 0;
    while (mirror.due.size() != 0 && wait_cycles < 200_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (mirror.due.size() != 0) begin
      mirror.errors++;
      $display("%0t: %0d listing entries never arrived", $time, mirror.due.size());
    end
    $display("Covered %0d commands and %0d listing entries; deepest store %0d of %0d.",
             items_taken, mirror.entries_checked, mirror.deepest, DEPTH);
    $display("Refused inserts on a full store: %0d; deletes at absent positions: %0d.",
             mirror.full_drops, mirror.missed_deletes);
    if (mirror.errors == 0) begin
      $display("sequence_store_insert_delete_top verification clean");
    end else begin
      $display("sequence_store_insert_delete_top verification failed");
    end
    $finish;
  end

endmodule
